[sv/khc_pkg.sv]
// Shared types and constants of the Hamming k-medoids clustering core.
`timescale 1ns / 1ps
package khc_pkg;

    localparam int DIST_W = 9;
    localparam int LOSS_W = 23;

    localparam logic [LOSS_W-1:0] LOSS_MAX = 23'h7FFFFF;

    localparam logic [2:0] REG_HAP_COUNT     = 3'd0;
    localparam logic [2:0] REG_WORDS_PER_HAP = 3'd1;
    localparam logic [2:0] REG_SITE_COUNT    = 3'd2;
    localparam logic [2:0] REG_MEDOID_COUNT  = 3'd3;
    localparam logic [2:0] REG_SWAP_POLICY   = 3'd4;
    localparam logic [2:0] REG_STOP_DELTA    = 3'd5;

    typedef enum logic [1:0] {
        CMD_LOAD       = 2'd0,
        CMD_SET_MEDOID = 2'd1,
        CMD_RUN        = 2'd2,
        CMD_QUERY      = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [5:0]  hap_index;
        logic [1:0]  word_index;
        logic [63:0] word_data;
        logic [3:0]  slot_index;
    } item_t;

    typedef struct packed {
        logic [3:0]        slot_out;
        logic [5:0]        hap_out;
        logic [DIST_W-1:0] distance;
        logic [LOSS_W-1:0] total_loss;
        logic              last;
    } result_t;

    typedef struct packed {
        logic store_wr;
        logic med_wr;
        logic h_clr;
        logic h_inc;
        logic h_load;
        logic k_clr;
        logic k_inc;
        logic c_clr;
        logic c_inc;
        logic dist_start;
        logic dist_add;
        logic b_ld_medk;
        logic b_ld_asg;
        logic ov;
        logic cmp_upd;
        logic asg_wr;
        logic asg_sel_c;
        logic sum_clr;
        logic sum_add;
        logic loss_commit;
        logic last_ld;
        logic orig_ld;
        logic swap_try;
        logic emit_run;
        logic emit_query;
    } ctl_t;

    typedef struct packed {
        logic nh_zero;
        logic nm_zero;
        logic nwords_zero;
        logic h_last;
        logic k_last;
        logic c_last;
        logic w_last;
        logic skip_cand;
        logic cont_pass;
        logic out_free;
    } sts_t;

endpackage

[sv/khc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module khc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/khc_dp.sv]
// Datapath: configuration, haplotype store, medoid table, distance and loss units.
`timescale 1ns / 1ps
module khc_dp import khc_pkg::*; #(
    parameter int MAX_HAPS    = 64,
    parameter int MAX_WORDS   = 4,
    parameter int MAX_MEDOIDS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_data,
    input  ctl_t        ctl,
    output sts_t        sts,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam int HW    = $clog2(MAX_HAPS);
    localparam int HCW   = $clog2(MAX_HAPS + 1);
    localparam int WW    = MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1;
    localparam int KW    = MAX_MEDOIDS > 1 ? $clog2(MAX_MEDOIDS) : 1;
    localparam int MCW   = $clog2(MAX_MEDOIDS + 1);
    localparam int DEPTH = MAX_HAPS * MAX_WORDS;
    localparam int SAW   = $clog2(DEPTH);
    localparam int ASG_W = KW + DIST_W;

    logic [6:0]        hap_count_reg;
    logic [2:0]        words_reg;
    logic [8:0]        sites_cfg_reg;
    logic [4:0]        medoids_reg;
    logic              policy_reg;
    logic [LOSS_W-1:0] delta_reg;

    logic [HW-1:0]     h_reg;
    logic [HW-1:0]     c_reg;
    logic [KW-1:0]     k_reg;
    logic [WW-1:0]     w_reg;
    logic [HW-1:0]     b_reg;
    logic [HW-1:0]     orig_reg;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] bd_reg;
    logic [KW-1:0]     bs_reg;
    logic [LOSS_W-1:0] sum_reg;
    logic [LOSS_W-1:0] best_loss_reg;
    logic [LOSS_W-1:0] last_reg;
    logic [HCW-1:0]    fill_reg;
    logic              asg_ok_reg;
    logic [5:0]        q_hap_reg;
    logic              q_oob_reg;
    logic              result_valid_reg;
    result_t           result_reg;
    logic [HW-1:0]     med_reg [MAX_MEDOIDS];

    logic [HCW-1:0]    nh;
    logic [MCW-1:0]    nm;
    logic [4:0]        wcap;
    logic [10:0]       cap;
    logic [8:0]        sites;
    logic [3:0]        nwords;
    logic [9:0]        rem;
    logic [63:0]       mask;
    logic [63:0]       diff;
    logic [6:0]        pop;
    logic [17:0]       sq;
    logic [23:0]       sum_wide;
    logic              hap_ok;
    logic              word_ok;
    logic              slot_ok;
    logic              swap_take;

    logic [SAW-1:0]    st_waddr;
    logic [SAW-1:0]    st_a_raddr;
    logic [SAW-1:0]    st_b_raddr;
    logic [63:0]       st_a_rd;
    logic [63:0]       st_b_rd;
    logic              st_we;

    logic [HW-1:0]     asg_raddr;
    logic [ASG_W-1:0]  asg_rd;
    logic [KW-1:0]     asg_slot;
    logic [DIST_W-1:0] asg_dist;

    logic [KW-1:0]     med_ra;
    logic [HW-1:0]     med_rd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hap_count_reg <= 7'd64;
            words_reg     <= 3'd1;
            sites_cfg_reg <= 9'd64;
            medoids_reg   <= 5'd4;
            policy_reg    <= 1'b0;
            delta_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HAP_COUNT:     hap_count_reg <= cfg_data[6:0];
                REG_WORDS_PER_HAP: words_reg     <= cfg_data[2:0];
                REG_SITE_COUNT:    sites_cfg_reg <= cfg_data[8:0];
                REG_MEDOID_COUNT:  medoids_reg   <= cfg_data[4:0];
                REG_SWAP_POLICY:   policy_reg    <= cfg_data[0];
                REG_STOP_DELTA:    delta_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign nh = (32'(hap_count_reg) >= MAX_HAPS) ? HCW'(MAX_HAPS) : HCW'(hap_count_reg);
    assign nm = (32'(medoids_reg) >= MAX_MEDOIDS) ? MCW'(MAX_MEDOIDS) : MCW'(medoids_reg);
    assign wcap   = (32'(words_reg) >= MAX_WORDS) ? 5'(MAX_WORDS) : 5'(words_reg);
    assign cap    = {wcap, 6'b0};
    assign sites  = (11'(sites_cfg_reg) < cap) ? sites_cfg_reg : 9'(cap);
    assign nwords = 4'((10'(sites) + 10'd63) >> 6);
    assign rem    = 10'(sites) - (10'(w_reg) << 6);
    assign mask   = (rem < 10'd64) ? ((64'd1 << rem[5:0]) - 64'd1) : '1;
    assign diff   = (st_a_rd ^ st_b_rd) & mask;
    assign pop    = 7'($countones(diff));
    assign sq     = 18'(acc_reg) * 18'(acc_reg);
    assign sum_wide = 24'(sum_reg) + 24'(sq);

    assign hap_ok  = 32'(item.hap_index) < MAX_HAPS;
    assign word_ok = 32'(item.word_index) < MAX_WORDS;
    assign slot_ok = 32'(item.slot_index) < MAX_MEDOIDS;

    // haplotype store, one copy per operand
    assign st_we      = ctl.store_wr && hap_ok && word_ok;
    assign st_waddr   = SAW'(item.hap_index) * SAW'(MAX_WORDS) + SAW'(item.word_index);
    assign st_a_raddr = SAW'(h_reg) * SAW'(MAX_WORDS) + SAW'(w_reg);
    assign st_b_raddr = SAW'(b_reg) * SAW'(MAX_WORDS) + SAW'(w_reg);

    khc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_store_a (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (item.word_data),
        .raddr (st_a_raddr),
        .rdata (st_a_rd)
    );

    khc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_store_b (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (item.word_data),
        .raddr (st_b_raddr),
        .rdata (st_b_rd)
    );

    // assignment store; entries at or beyond the fill mark read as zero
    assign asg_raddr = ctl.asg_sel_c ? c_reg : h_reg;

    khc_ram #(.WIDTH(ASG_W), .DEPTH(MAX_HAPS)) u_assign (
        .clk   (clk),
        .we    (ctl.asg_wr),
        .waddr (h_reg),
        .wdata ({bs_reg, bd_reg}),
        .raddr (asg_raddr),
        .rdata (asg_rd)
    );

    assign asg_slot = asg_ok_reg ? asg_rd[ASG_W-1:DIST_W] : '0;
    assign asg_dist = asg_ok_reg ? asg_rd[DIST_W-1:0] : '0;

    assign med_ra    = ctl.b_ld_asg ? asg_slot : k_reg;
    assign med_rd    = med_reg[med_ra];
    assign swap_take = ctl.swap_try && (sum_reg < best_loss_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_MEDOIDS; i++)
            begin
                med_reg[i] <= '0;
            end
            best_loss_reg    <= '0;
            fill_reg         <= '0;
            asg_ok_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.med_wr && hap_ok && slot_ok)
            begin
                med_reg[KW'(item.slot_index)] <= HW'(item.hap_index);
            end
            else if (swap_take)
            begin
                med_reg[k_reg] <= c_reg;
            end
            if (ctl.loss_commit || swap_take)
            begin
                best_loss_reg <= sum_reg;
            end
            if (ctl.asg_wr && (HCW'(h_reg) + HCW'(1) > fill_reg))
            begin
                fill_reg <= HCW'(h_reg) + HCW'(1);
            end
            asg_ok_reg <= HCW'(asg_raddr) < fill_reg;
            if (ctl.emit_run || ctl.emit_query)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.h_clr)
        begin
            h_reg <= '0;
        end
        else if (ctl.h_inc)
        begin
            h_reg <= h_reg + HW'(1);
        end
        else if (ctl.h_load)
        begin
            h_reg <= HW'(item.hap_index);
        end
        if (ctl.h_load)
        begin
            q_hap_reg <= item.hap_index;
            q_oob_reg <= !hap_ok;
        end
        if (ctl.c_clr)
        begin
            c_reg <= '0;
        end
        else if (ctl.c_inc)
        begin
            c_reg <= c_reg + HW'(1);
        end
        if (ctl.k_clr)
        begin
            k_reg <= '0;
        end
        else if (ctl.k_inc)
        begin
            k_reg <= k_reg + KW'(1);
        end
        if (ctl.dist_start)
        begin
            w_reg   <= '0;
            acc_reg <= '0;
        end
        else if (ctl.dist_add)
        begin
            w_reg   <= w_reg + WW'(1);
            acc_reg <= acc_reg + DIST_W'(pop);
        end
        if (ctl.b_ld_medk)
        begin
            b_reg <= med_rd;
        end
        else if (ctl.b_ld_asg)
        begin
            b_reg <= (ctl.ov && asg_slot == k_reg) ? c_reg : med_rd;
        end
        if (ctl.cmp_upd && (k_reg == '0 || acc_reg < bd_reg))
        begin
            bd_reg <= acc_reg;
            bs_reg <= k_reg;
        end
        if (ctl.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (ctl.sum_add)
        begin
            sum_reg <= sum_wide[LOSS_W] ? LOSS_MAX : sum_wide[LOSS_W-1:0];
        end
        if (ctl.last_ld)
        begin
            last_reg <= best_loss_reg;
        end
        if (ctl.orig_ld)
        begin
            orig_reg <= med_rd;
        end
        if (ctl.emit_run)
        begin
            result_reg.slot_out   <= 4'(k_reg);
            result_reg.hap_out    <= 6'(med_rd);
            result_reg.distance   <= '0;
            result_reg.total_loss <= best_loss_reg;
            result_reg.last       <= sts.k_last;
        end
        else if (ctl.emit_query)
        begin
            result_reg.slot_out   <= q_oob_reg ? 4'd0 : 4'(asg_slot);
            result_reg.hap_out    <= q_hap_reg;
            result_reg.distance   <= q_oob_reg ? '0 : asg_dist;
            result_reg.total_loss <= best_loss_reg;
            result_reg.last       <= 1'b1;
        end
    end

    assign sts.nh_zero     = nh == '0;
    assign sts.nm_zero     = nm == '0;
    assign sts.nwords_zero = nwords == 4'd0;
    assign sts.h_last      = (HCW'(h_reg) + HCW'(1)) == nh;
    assign sts.c_last      = (HCW'(c_reg) + HCW'(1)) == nh;
    assign sts.k_last      = (MCW'(k_reg) + MCW'(1)) == nm;
    assign sts.w_last      = (4'(w_reg) + 4'd1) == nwords;
    assign sts.skip_cand   = (c_reg == orig_reg) || (policy_reg && asg_slot != k_reg);
    assign sts.cont_pass   = (last_reg - best_loss_reg) > delta_reg;
    assign sts.out_free    = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[sv/khc_ctrl.sv]
// Controller: sequences assignment, loss evaluation, swap passes and result words.
`timescale 1ns / 1ps
module khc_ctrl import khc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    input  cmd_t command,
    input  sts_t sts,
    output ctl_t ctl,
    output logic item_stall
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_K,
        S_D_RD,
        S_D_ACC,
        S_A_CMP,
        S_A_WR,
        S_L_START,
        S_LS_RD,
        S_LS_B,
        S_LS_ADD,
        S_INIT,
        S_P_START,
        S_K_START,
        S_C_CHK,
        S_C_CHK2,
        S_S_DEC,
        S_C_NEXT,
        S_K_NEXT,
        S_P_END,
        S_EMIT,
        S_Q_RD,
        S_Q_EMIT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   ov_reg, ov_next;
    logic   stall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            ov_reg    <= 1'b0;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ov_reg    <= ov_next;
            stall_reg <= state_next != S_IDLE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ov_next    = ov_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (command)
                        CMD_LOAD:       ctl.store_wr = 1'b1;
                        CMD_SET_MEDOID: ctl.med_wr   = 1'b1;
                        CMD_RUN:
                        begin
                            if (!sts.nm_zero)
                            begin
                                ctl.h_clr  = 1'b1;
                                ctl.k_clr  = 1'b1;
                                state_next = sts.nh_zero ? S_L_START : S_A_K;
                            end
                        end
                        CMD_QUERY:
                        begin
                            ctl.h_load = 1'b1;
                            state_next = S_Q_RD;
                        end
                    endcase
                end
            end
            S_A_K:
            begin
                ctl.b_ld_medk  = 1'b1;
                ctl.dist_start = 1'b1;
                ret_next       = S_A_CMP;
                state_next     = S_D_RD;
            end
            S_D_RD:
            begin
                state_next = sts.nwords_zero ? ret_reg : S_D_ACC;
            end
            S_D_ACC:
            begin
                ctl.dist_add = 1'b1;
                state_next   = sts.w_last ? ret_reg : S_D_RD;
            end
            S_A_CMP:
            begin
                ctl.cmp_upd = 1'b1;
                if (sts.k_last)
                begin
                    state_next = S_A_WR;
                end
                else
                begin
                    ctl.k_inc  = 1'b1;
                    state_next = S_A_K;
                end
            end
            S_A_WR:
            begin
                ctl.asg_wr = 1'b1;
                ctl.k_clr  = 1'b1;
                if (sts.h_last)
                begin
                    state_next = S_L_START;
                end
                else
                begin
                    ctl.h_inc  = 1'b1;
                    state_next = S_A_K;
                end
            end
            S_L_START:
            begin
                ctl.h_clr   = 1'b1;
                ctl.sum_clr = 1'b1;
                ov_next     = 1'b0;
                state_next  = sts.nh_zero ? S_INIT : S_LS_RD;
            end
            S_LS_RD:
            begin
                state_next = S_LS_B;
            end
            S_LS_B:
            begin
                ctl.b_ld_asg   = 1'b1;
                ctl.ov         = ov_reg;
                ctl.dist_start = 1'b1;
                ret_next       = S_LS_ADD;
                state_next     = S_D_RD;
            end
            S_LS_ADD:
            begin
                ctl.sum_add = 1'b1;
                if (sts.h_last)
                begin
                    state_next = ov_reg ? S_S_DEC : S_INIT;
                end
                else
                begin
                    ctl.h_inc  = 1'b1;
                    state_next = S_LS_RD;
                end
            end
            S_INIT:
            begin
                ctl.loss_commit = 1'b1;
                state_next      = S_P_START;
            end
            S_P_START:
            begin
                ctl.last_ld = 1'b1;
                ctl.k_clr   = 1'b1;
                state_next  = S_K_START;
            end
            S_K_START:
            begin
                ctl.orig_ld = 1'b1;
                ctl.c_clr   = 1'b1;
                state_next  = sts.nh_zero ? S_K_NEXT : S_C_CHK;
            end
            S_C_CHK:
            begin
                ctl.asg_sel_c = 1'b1;
                state_next    = S_C_CHK2;
            end
            S_C_CHK2:
            begin
                if (sts.skip_cand)
                begin
                    state_next = S_C_NEXT;
                end
                else
                begin
                    ctl.h_clr   = 1'b1;
                    ctl.sum_clr = 1'b1;
                    ov_next     = 1'b1;
                    state_next  = S_LS_RD;
                end
            end
            S_S_DEC:
            begin
                ctl.swap_try = 1'b1;
                state_next   = S_C_NEXT;
            end
            S_C_NEXT:
            begin
                if (sts.c_last)
                begin
                    state_next = S_K_NEXT;
                end
                else
                begin
                    ctl.c_inc  = 1'b1;
                    state_next = S_C_CHK;
                end
            end
            S_K_NEXT:
            begin
                if (sts.k_last)
                begin
                    state_next = S_P_END;
                end
                else
                begin
                    ctl.k_inc  = 1'b1;
                    state_next = S_K_START;
                end
            end
            S_P_END:
            begin
                if (sts.cont_pass)
                begin
                    state_next = S_P_START;
                end
                else
                begin
                    ctl.k_clr  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit_run = 1'b1;
                    if (sts.k_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.k_inc = 1'b1;
                    end
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_EMIT;
            end
            S_Q_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit_query = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_stall = stall_reg;

endmodule

[sv/kmedoids_hamming_cluster_core.sv]
// Top level of the Hamming k-medoids clustering core.
// Use: configure through the cfg channel (index, data, valid/ready) while idle.
// Items enter on item/item_valid and are taken when item_stall is low.
// Load word and set medoid give no result word.
// Query gives one result word, marked by last.
// Run assigns every haplotype to its nearest medoid, then sweeps swap passes,
// and emits one result word per medoid slot, the final one marked by last.
// With N haplotypes and K slots, each pass runs up to K*N loss evaluations,
// all through the single distance unit, which reads both store copies once
// per word.
// item_stall stays high for the whole run or query.
// Results sit in an output register; result_stall holds them and the
// controller waits before writing the next one.
// Reset clears configuration to defaults, the medoid table, the loss and the
// assignment fill mark; the haplotype store keeps no reset value.
`timescale 1ns / 1ps
module kmedoids_hamming_cluster_core import khc_pkg::*; #(
    parameter int MAX_HAPS    = 64,
    parameter int MAX_WORDS   = 4,
    parameter int MAX_MEDOIDS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    khc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .command    (item.command),
        .sts        (sts),
        .ctl        (ctl),
        .item_stall (item_stall)
    );

    khc_dp #(
        .MAX_HAPS    (MAX_HAPS),
        .MAX_WORDS   (MAX_WORDS),
        .MAX_MEDOIDS (MAX_MEDOIDS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTH
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> item_stall)
        else $error("non-final run word while core idle");

    a_run_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.distance == '0)
        else $error("run word carries a distance");

    a_emit_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.emit_run && ctl.emit_query))
        else $error("run and query emitted together");
`endif

endmodule
